>>> rtl/tgs_pkg.sv
package tgs_pkg;

    // Position format: signed 32-bit fixed point with this many fraction bits
    localparam int POS_FRAC_BITS = 16;

    localparam logic [8:0]  DEG_FULL   = 9'd360;
    localparam logic [14:0] HOME_RESET = 15'd250;

    typedef enum logic [2:0] {
        CMD_HOME     = 3'd0,
        CMD_PEN_DOWN = 3'd1,
        CMD_PEN_UP   = 3'd2,
        CMD_TURN     = 3'd3,
        CMD_MOVE     = 3'd4
    } cmd_t;

    typedef enum logic [0:0] {
        CFG_HOME_X = 1'b0,
        CFG_HOME_Y = 1'b1
    } cfg_idx_t;

    // Command held in the input register, with the turn amount already reduced mod 360
    typedef struct packed {
        logic              valid;
        logic [2:0]        cmd;
        logic signed [15:0] amount;
        logic [8:0]        turn_mod;
    } tgs_item_t;

    // Quarter-wave sine table, unsigned Q0.15, 0..90 degrees
    typedef logic [14:0] sin_rom_t [91];

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Taylor series through x^13 in Q30, evaluated at elaboration
    function automatic sin_rom_t build_sin_rom();
        sin_rom_t        rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned plus;
        longint unsigned minus;
        longint unsigned s;
        longint unsigned q;
        for (int d = 0; d <= 90; d++) begin
            x     = (64'(d) * PI_Q30) / 64'd180;
            x2    = (x * x) >> 30;
            term  = x;
            plus  = term;
            term  = ((term * x2) >> 30) / 64'd6;
            minus = term;
            term  = ((term * x2) >> 30) / 64'd20;
            plus  = plus + term;
            term  = ((term * x2) >> 30) / 64'd42;
            minus = minus + term;
            term  = ((term * x2) >> 30) / 64'd72;
            plus  = plus + term;
            term  = ((term * x2) >> 30) / 64'd110;
            minus = minus + term;
            term  = ((term * x2) >> 30) / 64'd156;
            plus  = plus + term;
            s = (plus > minus) ? (plus - minus) : 64'd0;
            q = (s + 64'd16384) >> 15;
            if (q > 64'd32767) begin
                q = 64'd32767;
            end
            rom[d] = q[14:0];
        end
        return rom;
    endfunction

    localparam sin_rom_t SIN_ROM = build_sin_rom();

    localparam int HOME_W = (15 + POS_FRAC_BITS + 1 > 33) ? 15 + POS_FRAC_BITS + 1 : 33;

    // Home coordinate in position format, saturated to 32 bits
    function automatic logic signed [31:0] home_pos(input logic [14:0] h);
        logic [HOME_W-1:0] w;
        w = HOME_W'(h) << POS_FRAC_BITS;
        if (w > HOME_W'(32'h7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end
        return $signed(w[31:0]);
    endfunction

endpackage

>>> rtl/turtle_graphics_step.sv
// Path: after its command transfer, a result passes the input register, then the
// result register.
// Throughput: one command per cycle; only a pending segment that is not taken stalls
// the next pen-down move. Throughput is set by the single pass through the sine ROM,
// one 16x16 multiplier per axis and the 32-bit position add.
// Reset: synchronous, active low; home registers return to 250, turtle to home,
// heading 0, pen down, both channels empty. No clearing pass.
module turtle_graphics_step import tgs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [14:0]       cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_cmd,
    input  logic signed [15:0] s_amount,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [15:0] m_x_start,
    output logic signed [15:0] m_y_start,
    output logic signed [15:0] m_x_end,
    output logic signed [15:0] m_y_end
);

    logic [14:0] home_x_reg;
    logic [14:0] home_y_reg;
    tgs_item_t   item;
    logic        take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            home_x_reg <= HOME_RESET;
            home_y_reg <= HOME_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_HOME_X: home_x_reg <= cfg_data;
                CFG_HOME_Y: home_y_reg <= cfg_data;
            endcase
        end
    end

    tgs_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_cmd    (s_cmd),
        .s_amount (s_amount),
        .take     (take),
        .item     (item)
    );

    tgs_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .home_x    (home_x_reg),
        .home_y    (home_y_reg),
        .item      (item),
        .take      (take),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_x_start (m_x_start),
        .m_y_start (m_y_start),
        .m_x_end   (m_x_end),
        .m_y_end   (m_y_end)
    );

endmodule

>>> rtl/tgs_in_stage.sv
module tgs_in_stage import tgs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_cmd,
    input  logic signed [15:0] s_amount,
    input  logic              take,
    output tgs_item_t         item
);

    // amount + 100*360 is always positive; divide by 360 via reciprocal
    localparam logic [16:0] TURN_BIAS   = 17'd36000;
    localparam logic [33:0] RECIP_360   = 34'd93206;
    localparam int          RECIP_SHIFT = 25;

    logic               valid_reg;
    logic [2:0]         cmd_reg;
    logic signed [15:0] amount_reg;
    logic [8:0]         turn_mod_reg;
    logic [16:0]        biased;
    logic [33:0]        recip_prod;
    logic [8:0]         quot;
    logic [16:0]        quot_x360;
    logic [16:0]        rem;
    logic [8:0]         turn_mod;

    always_comb begin
        biased     = {s_amount[15], s_amount} + TURN_BIAS;
        recip_prod = 34'(biased) * RECIP_360;
        quot       = recip_prod[RECIP_SHIFT +: 9];
        quot_x360  = 17'(quot) * 17'(DEG_FULL);
        rem        = biased - quot_x360;
        // quotient may come out one low
        if (rem >= 17'(DEG_FULL)) begin
            turn_mod = 9'(rem - 17'(DEG_FULL));
        end else begin
            turn_mod = rem[8:0];
        end
    end

    assign s_ready = !valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg      <= s_cmd;
            amount_reg   <= s_amount;
            turn_mod_reg <= turn_mod;
        end
    end

    always_comb begin
        item.valid    = valid_reg;
        item.cmd      = cmd_reg;
        item.amount   = amount_reg;
        item.turn_mod = turn_mod_reg;
    end

endmodule

>>> rtl/tgs_core.sv
module tgs_core import tgs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [14:0]       home_x,
    input  logic [14:0]       home_y,
    input  tgs_item_t         item,
    output logic              take,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [15:0] m_x_start,
    output logic signed [15:0] m_y_start,
    output logic signed [15:0] m_x_end,
    output logic signed [15:0] m_y_end
);

    localparam int PROD_W  = 33;
    localparam int SHL     = (POS_FRAC_BITS >= 15) ? POS_FRAC_BITS - 15 : 0;
    localparam int SHR     = (POS_FRAC_BITS < 15) ? 15 - POS_FRAC_BITS : 0;
    localparam int DELTA_W = PROD_W + SHL;
    localparam int SUM_W   = DELTA_W + 1;
    localparam int IP_W    = 33 - POS_FRAC_BITS;
    localparam int IPX_W   = (IP_W > 17) ? IP_W : 17;

    logic signed [31:0] pos_x_reg, pos_x_next;
    logic signed [31:0] pos_y_reg, pos_y_next;
    logic [8:0]         heading_reg, heading_next;
    logic               pen_reg, pen_next;
    logic               m_valid_reg;
    logic signed [15:0] x_start_reg, y_start_reg, x_end_reg, y_end_reg;

    logic               emits;
    logic               out_free;
    logic [9:0]         turn_sum;
    logic [8:0]         cos_idx;
    logic signed [15:0] sin_val, cos_val;
    logic signed [31:0] mul_x, mul_y;
    logic signed [PROD_W-1:0]  prod_x, prod_y;
    logic signed [DELTA_W-1:0] dx, dy;
    logic signed [SUM_W-1:0]   sum_x, sum_y;
    logic signed [31:0] new_x, new_y;

    function automatic logic signed [15:0] rom_sin(input logic [8:0] h);
        logic [6:0]         idx;
        logic               neg;
        logic signed [15:0] mag;
        if (h <= 9'd90) begin
            idx = h[6:0];
            neg = 1'b0;
        end else if (h <= 9'd180) begin
            idx = 7'(9'd180 - h);
            neg = 1'b0;
        end else if (h <= 9'd270) begin
            idx = 7'(h - 9'd180);
            neg = 1'b1;
        end else begin
            idx = 7'(DEG_FULL - h);
            neg = 1'b1;
        end
        mag = $signed({1'b0, SIN_ROM[idx]});
        return neg ? -mag : mag;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        if (&v[SUM_W-1:31] || ~|v[SUM_W-1:31]) begin
            return v[31:0];
        end
        return v[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    // integer part, truncated toward zero, saturated to 16 bits
    function automatic logic signed [15:0] int_part16(input logic signed [31:0] p);
        logic signed [32:0]      biased;
        logic signed [IPX_W-1:0] ip;
        biased = {p[31], p} + (p[31] ? 33'((34'd1 << POS_FRAC_BITS) - 34'd1) : 33'd0);
        ip     = IPX_W'($signed(biased[32:POS_FRAC_BITS]));
        if (&ip[IPX_W-1:15] || ~|ip[IPX_W-1:15]) begin
            return ip[15:0];
        end
        return ip[IPX_W-1] ? 16'sh8000 : 16'sh7FFF;
    endfunction

    assign emits    = (item.cmd == CMD_MOVE) && pen_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign take     = item.valid && (!emits || out_free);

    always_comb begin
        cos_idx = (heading_reg < 9'd270) ? heading_reg + 9'd90 : heading_reg - 9'd270;
        sin_val = rom_sin(heading_reg);
        cos_val = rom_sin(cos_idx);
        mul_x   = item.amount * sin_val;
        mul_y   = item.amount * cos_val;
        prod_x  = {mul_x[31], mul_x};
        prod_y  = -{mul_y[31], mul_y};
        dx      = (DELTA_W'(prod_x) <<< SHL) >>> SHR;
        dy      = (DELTA_W'(prod_y) <<< SHL) >>> SHR;
        sum_x   = SUM_W'(pos_x_reg) + SUM_W'(dx);
        sum_y   = SUM_W'(pos_y_reg) + SUM_W'(dy);
        new_x   = sat32(sum_x);
        new_y   = sat32(sum_y);
        turn_sum = {1'b0, heading_reg} + {1'b0, item.turn_mod};
    end

    always_comb begin
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        heading_next = heading_reg;
        pen_next     = pen_reg;
        case (cmd_t'(item.cmd))
            CMD_HOME: begin
                pos_x_next   = home_pos(home_x);
                pos_y_next   = home_pos(home_y);
                heading_next = '0;
                pen_next     = 1'b1;
            end
            CMD_PEN_DOWN: pen_next = 1'b1;
            CMD_PEN_UP:   pen_next = 1'b0;
            CMD_TURN: begin
                if (turn_sum >= 10'(DEG_FULL)) begin
                    heading_next = 9'(turn_sum - 10'(DEG_FULL));
                end else begin
                    heading_next = turn_sum[8:0];
                end
            end
            CMD_MOVE: begin
                pos_x_next = new_x;
                pos_y_next = new_y;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= home_pos(HOME_RESET);
            pos_y_reg   <= home_pos(HOME_RESET);
            heading_reg <= '0;
            pen_reg     <= 1'b1;
        end else if (take) begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            heading_reg <= heading_next;
            pen_reg     <= pen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take && emits) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && emits) begin
            x_start_reg <= int_part16(pos_x_reg);
            y_start_reg <= int_part16(pos_y_reg);
            x_end_reg   <= int_part16(new_x);
            y_end_reg   <= int_part16(new_y);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_x_start = x_start_reg;
    assign m_y_start = y_start_reg;
    assign m_x_end   = x_end_reg;
    assign m_y_end   = y_end_reg;

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        heading_reg < DEG_FULL)
        else $error("heading out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        take && emits |-> !(m_valid_reg && !m_ready))
        else $error("segment overwrote a pending result");

    a_move_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        take && emits |=> m_valid_reg)
        else $error("pen-down move gave no result");

    a_pen_up: assert property (@(posedge aclk) disable iff (!aresetn)
        take && item.cmd == CMD_PEN_UP |=> !pen_reg)
        else $error("pen up not applied");

    a_stall_holds_item: assert property (@(posedge aclk) disable iff (!aresetn)
        item.valid && !take |=> item.valid)
        else $error("stalled command lost");

endmodule

>>> tb/tb_turtle_graphics_step.sv
module tb_turtle_graphics_step;
    import tgs_pkg::*;

    localparam int FRAC       = POS_FRAC_BITS;
    localparam int UP_SHIFT   = (FRAC >= 15) ? FRAC - 15 : 0;
    localparam int DOWN_SHIFT = (FRAC < 15) ? 15 - FRAC : 0;
    localparam longint unsigned PI_Q30_TB = 64'd3373259426;
    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [15:0] amount;
    } turtle_cmd_t;

    typedef struct packed {
        logic signed [15:0] xs;
        logic signed [15:0] ys;
        logic signed [15:0] xe;
        logic signed [15:0] ye;
    } segment_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [0:0]         cfg_index = CFG_HOME_X;
    logic [14:0]        cfg_data  = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [2:0]         s_cmd     = CMD_HOME;
    logic signed [15:0] s_amount  = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic signed [15:0] m_x_start;
    logic signed [15:0] m_y_start;
    logic signed [15:0] m_x_end;
    logic signed [15:0] m_y_end;

    turtle_graphics_step dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_amount  (s_amount),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_x_start (m_x_start),
        .m_y_start (m_y_start),
        .m_x_end   (m_x_end),
        .m_y_end   (m_y_end)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // turtle state as the block should hold it
    int                 sine_tab [91];
    logic [14:0]        home_x_reg = HOME_RESET;
    logic [14:0]        home_y_reg = HOME_RESET;
    logic signed [31:0] turtle_x;
    logic signed [31:0] turtle_y;
    logic [8:0]         turtle_hdg;
    bit                 turtle_pen;

    turtle_cmd_t cmd_q [$];
    segment_t    seg_q [$];
    int          err_cnt     = 0;
    int          tx_idle_pct = 26;
    int          rx_idle_pct = 26;
    bit          rx_hold_arm = 1'b0;

    // quarter wave, Q30 Taylor series through x^13, rounded to Q15
    function automatic void build_sine_tab();
        longint unsigned x, x2, term, acc_p, acc_m, s, q;
        for (int d = 0; d <= 90; d++) begin
            x     = longint'(d) * PI_Q30_TB / 180;
            x2    = (x * x) >> 30;
            term  = x;
            acc_p = 0;
            acc_m = 0;
            for (int k = 1; k <= 7; k++) begin
                if (k % 2 == 1) acc_p += term;
                else acc_m += term;
                term = (term * x2) >> 30;
                term = term / (longint'(2 * k) * longint'(2 * k + 1));
            end
            s = (acc_p > acc_m) ? acc_p - acc_m : 0;
            q = (s + 64'd16384) >> 15;
            if (q > 32767) q = 32767;
            sine_tab[d] = int'(q);
        end
    endfunction

    function automatic int sine_deg(int unsigned h);
        h = h % 360;
        if (h <= 90) return sine_tab[h];
        if (h <= 180) return sine_tab[180 - h];
        if (h <= 270) return -sine_tab[h - 180];
        return -sine_tab[360 - h];
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v > POS_MAX) return 32'sh7FFF_FFFF;
        if (v < POS_MIN) return 32'sh8000_0000;
        return 32'(v);
    endfunction

    // integer part toward zero, clamped to 16 bits
    function automatic logic signed [15:0] pixel_of(logic signed [31:0] p);
        longint v;
        v = longint'(p) / (longint'(1) << FRAC);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    function automatic void go_home();
        turtle_x   = sat32(longint'(home_x_reg) << FRAC);
        turtle_y   = sat32(longint'(home_y_reg) << FRAC);
        turtle_hdg = '0;
        turtle_pen = 1'b1;
    endfunction

    function automatic void advance_turtle(logic [2:0] cmd, logic signed [15:0] amt);
        longint             prod_s, prod_c;
        logic signed [31:0] nx, ny;
        int                 h;
        segment_t           seg;
        case (cmd)
            CMD_HOME: go_home();
            CMD_PEN_DOWN: turtle_pen = 1'b1;
            CMD_PEN_UP: turtle_pen = 1'b0;
            CMD_TURN: begin
                h = (int'(turtle_hdg) + int'(amt)) % 360;
                if (h < 0) h += 360;
                turtle_hdg = 9'(h);
            end
            CMD_MOVE: begin
                prod_s = longint'(amt) * sine_deg(turtle_hdg);
                prod_c = -(longint'(amt) * sine_deg(turtle_hdg + 90));
                // Q15 product into position format; right shift floors
                nx = sat32(longint'(turtle_x) + ((prod_s <<< UP_SHIFT) >>> DOWN_SHIFT));
                ny = sat32(longint'(turtle_y) + ((prod_c <<< UP_SHIFT) >>> DOWN_SHIFT));
                if (turtle_pen) begin
                    seg.xs = pixel_of(turtle_x);
                    seg.ys = pixel_of(turtle_y);
                    seg.xe = pixel_of(nx);
                    seg.ye = pixel_of(ny);
                    seg_q.push_back(seg);
                end
                turtle_x = nx;
                turtle_y = ny;
            end
            default: ;
        endcase
    endfunction

    // command driver
    always @(posedge aclk) begin : drive
        turtle_cmd_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_turtle(s_cmd, s_amount);
            end
            if (!s_valid || s_ready) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = cmd_q.pop_front();
                    s_valid  <= 1'b1;
                    s_cmd    <= nxt.cmd;
                    s_amount <= nxt.amount;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // segment sink backpressure, with one long hold-off when armed
    always @(posedge aclk) begin : sink
        int  hold_left;
        bit  hold_done;
        if (rx_hold_arm && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // segment checker
    always @(posedge aclk) begin : check
        segment_t want, got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_x_start, m_y_start, m_x_end, m_y_end};
            if (seg_q.size() == 0) begin
                $display("%0t: segment with no move pending: (%0d,%0d)-(%0d,%0d)",
                         $time, got.xs, got.ys, got.xe, got.ye);
                err_cnt++;
            end else begin
                want = seg_q.pop_front();
                if (got !== want) begin
                    $display("%0t: segment expected (%0d,%0d)-(%0d,%0d) got (%0d,%0d)-(%0d,%0d)",
                             $time, want.xs, want.ys, want.xe, want.ye,
                             got.xs, got.ys, got.xe, got.ye);
                    err_cnt++;
                end
            end
        end
    end

    task automatic push(logic [2:0] cmd, logic signed [15:0] amt);
        turtle_cmd_t c;
        c.cmd    = cmd;
        c.amount = amt;
        cmd_q.push_back(c);
    endtask

    task automatic push_random(int n);
        int                 r;
        logic signed [15:0] amt;
        for (int i = 0; i < n; i++) begin
            r   = $urandom_range(99);
            amt = 16'($urandom);
            if (r < 48) begin
                if ($urandom_range(7) != 0) amt = 16'(int'($urandom_range(800)) - 400);
                push(CMD_MOVE, amt);
            end else if (r < 72) begin
                if ($urandom_range(1) != 0) amt = 16'(int'($urandom_range(720)) - 360);
                push(CMD_TURN, amt);
            end else if (r < 82) begin
                push(CMD_PEN_DOWN, amt);
            end else if (r < 89) begin
                push(CMD_PEN_UP, amt);
            end else if (r < 94) begin
                push(CMD_HOME, amt);
            end else begin
                push(3'($urandom_range(CMD_SPARE_C, CMD_SPARE_A)), amt);
            end
        end
    endtask

    // home registers only take effect on the next home command
    task automatic set_home(cfg_idx_t idx, logic [14:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_HOME_X) home_x_reg = v;
        else home_y_reg = v;
    endtask

    // all commands taken, all segments seen, plus the pipeline depth
    task automatic wait_drained();
        do @(negedge aclk);
        while (cmd_q.size() != 0 || s_valid || seg_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        build_sine_tab();
        go_home();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: zero step, extremes of amount, wraps, pen up, spare codes
        push(CMD_MOVE, 16'sd0);
        push(CMD_MOVE, 16'sd100);
        push(CMD_TURN, 16'sd90);
        push(CMD_MOVE, -16'sd50);
        push(CMD_TURN, -16'sd450);
        push(CMD_TURN, 16'sd45);
        push(CMD_MOVE, 16'sh7FFF);
        push(CMD_MOVE, 16'sh8000);
        push(CMD_TURN, 16'sh7FFF);
        push(CMD_MOVE, 16'sd1000);
        push(CMD_TURN, 16'sh8000);
        push(CMD_PEN_UP, 16'sh7FFF);
        push(CMD_MOVE, 16'sd500);
        push(CMD_PEN_DOWN, 16'sh8000);
        push(CMD_MOVE, -16'sd1);
        push(CMD_SPARE_A, 16'sh5555);
        push(CMD_SPARE_A + 3'd1, 16'shAAAA);
        push(CMD_SPARE_C, 16'shFFFF);
        push(CMD_HOME, 16'sh1234);
        push(CMD_TURN, 16'sd180);
        push(CMD_MOVE, 16'sh7FFF);
        push(CMD_MOVE, 16'sh7FFF);
        push(CMD_TURN, 16'sd270);
        push(CMD_MOVE, 16'sh8000);
        wait_drained();

        set_home(CFG_HOME_X, 15'd0);
        set_home(CFG_HOME_Y, 15'd0);
        @(negedge aclk);
        push(CMD_HOME, 16'sd0);
        push_random(80);
        wait_drained();

        // long sink hold while commands keep coming: pipeline fills, s_ready drops
        set_home(CFG_HOME_X, 15'h7FFF);
        set_home(CFG_HOME_Y, 15'h7FFF);
        @(negedge aclk);
        tx_idle_pct = 0;
        push(CMD_HOME, 16'sd0);
        for (int i = 0; i < 60; i++) begin
            push(CMD_MOVE, 16'(int'($urandom_range(400)) - 200));
        end
        push_random(40);
        rx_hold_arm = 1'b1;
        wait_drained();

        // back-to-back stretch, no idling on either side
        set_home(CFG_HOME_X, 15'($urandom));
        set_home(CFG_HOME_Y, 15'($urandom));
        @(negedge aclk);
        rx_idle_pct = 0;
        push(CMD_HOME, 16'sd0);
        push_random(110);
        wait_drained();

        set_home(CFG_HOME_X, 15'($urandom));
        set_home(CFG_HOME_Y, HOME_RESET);
        @(negedge aclk);
        tx_idle_pct = 26;
        rx_idle_pct = 26;
        push(CMD_HOME, 16'sd0);
        push_random(110);
        wait_drained();

        repeat (10) @(negedge aclk);
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
